// File: hdl/asmc_pkg.sv
package asmc_pkg;

  localparam int NUM_SUBSYSTEMS = 8;

  // Mask bits for subsystems that exist, limited to the eight stored bits.
  localparam logic [7:0] VALID_BITS =
    (NUM_SUBSYSTEMS >= 8) ? 8'hFF : 8'((1 << NUM_SUBSYSTEMS) - 1);

  localparam logic [7:0] MASK_RESET = 8'hFF;

  typedef enum logic [2:0] {
    REQ_INIT       = 3'd0,
    REQ_ARM        = 3'd1,
    REQ_MANUAL     = 3'd2,
    REQ_RELINQUISH = 3'd3,
    REQ_DISARM     = 3'd4,
    REQ_SHUTDOWN   = 3'd5,
    REQ_FIRE       = 3'd6,
    REQ_FIRE_SUPP  = 3'd7
  } req_t;

  typedef enum logic [5:0] {
    MODE_UNINIT   = 6'b000001,
    MODE_INIT     = 6'b000010,
    MODE_ARMED    = 6'b000100,
    MODE_MANUAL   = 6'b001000,
    MODE_DISARMED = 6'b010000,
    MODE_SHUTDOWN = 6'b100000
  } mode_t;

  localparam logic [2:0] MODE_CODE_UNINIT   = 3'd0;
  localparam logic [2:0] MODE_CODE_INIT     = 3'd1;
  localparam logic [2:0] MODE_CODE_ARMED    = 3'd2;
  localparam logic [2:0] MODE_CODE_MANUAL   = 3'd3;
  localparam logic [2:0] MODE_CODE_DISARMED = 3'd4;
  localparam logic [2:0] MODE_CODE_SHUTDOWN = 3'd5;

  localparam logic [1:0] MOTOR_SILENT = 2'd0;
  localparam logic [1:0] MOTOR_QUIET  = 2'd1;
  localparam logic [1:0] MOTOR_LOUD   = 2'd2;

  typedef enum logic [2:0] {
    ST_TRANSITION = 3'd0,
    ST_NEW        = 3'd1,
    ST_ALREADY    = 3'd2,
    ST_UNUSED     = 3'd3,
    ST_INVALID    = 3'd4,
    ST_IGNORED    = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0] event_status;
    logic [1:0] motor_sound;
    logic       screen_on;
    logic [2:0] mode;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] code;
    case (m)
      MODE_UNINIT:   code = MODE_CODE_UNINIT;
      MODE_INIT:     code = MODE_CODE_INIT;
      MODE_ARMED:    code = MODE_CODE_ARMED;
      MODE_MANUAL:   code = MODE_CODE_MANUAL;
      MODE_DISARMED: code = MODE_CODE_DISARMED;
      MODE_SHUTDOWN: code = MODE_CODE_SHUTDOWN;
      default:       code = MODE_CODE_UNINIT;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/asmc_step.sv
module asmc_step (
  input  asmc_pkg::mode_t   mode,
  input  logic [7:0]        done_flags,
  input  logic [7:0]        mask,
  input  logic [2:0]        req_type,
  input  logic [3:0]        subsystem_index,
  output asmc_pkg::mode_t   mode_nxt,
  output logic [7:0]        done_flags_nxt,
  output asmc_pkg::result_t result
);

  asmc_pkg::mode_t   mode_eff;
  asmc_pkg::status_t status;
  logic [7:0]        flags_set;
  logic [2:0]        code;

  assign flags_set = done_flags | (8'd1 << subsystem_index[2:0]);

  always_comb begin
    // A completed init set (including an empty mask) takes effect before the event.
    mode_eff = mode;
    if ((mode == asmc_pkg::MODE_UNINIT) &&
        ((mask & asmc_pkg::VALID_BITS & ~done_flags) == 8'd0)) begin
      mode_eff = asmc_pkg::MODE_INIT;
    end

    mode_nxt       = mode_eff;
    done_flags_nxt = done_flags;
    status         = asmc_pkg::ST_IGNORED;

    case (mode_eff)
      asmc_pkg::MODE_UNINIT: begin
        if (req_type == asmc_pkg::REQ_INIT) begin
          if (subsystem_index >= 4'(asmc_pkg::NUM_SUBSYSTEMS)) begin
            status = asmc_pkg::ST_INVALID;
          end else if (subsystem_index[3] || !mask[subsystem_index[2:0]]) begin
            status = asmc_pkg::ST_UNUSED;
          end else if (done_flags[subsystem_index[2:0]]) begin
            status = asmc_pkg::ST_ALREADY;
          end else begin
            done_flags_nxt = flags_set;
            status         = asmc_pkg::ST_NEW;
            if ((mask & asmc_pkg::VALID_BITS & ~flags_set) == 8'd0) begin
              mode_nxt = asmc_pkg::MODE_INIT;
            end
          end
        end
      end
      asmc_pkg::MODE_INIT: begin
        if (req_type == asmc_pkg::REQ_ARM) begin
          mode_nxt = asmc_pkg::MODE_ARMED;
          status   = asmc_pkg::ST_TRANSITION;
        end
      end
      asmc_pkg::MODE_ARMED: begin
        if (req_type == asmc_pkg::REQ_MANUAL) begin
          mode_nxt = asmc_pkg::MODE_MANUAL;
          status   = asmc_pkg::ST_TRANSITION;
        end else if (req_type == asmc_pkg::REQ_DISARM) begin
          mode_nxt = asmc_pkg::MODE_DISARMED;
          status   = asmc_pkg::ST_TRANSITION;
        end
      end
      asmc_pkg::MODE_MANUAL: begin
        if (req_type == asmc_pkg::REQ_RELINQUISH) begin
          mode_nxt = asmc_pkg::MODE_ARMED;
          status   = asmc_pkg::ST_TRANSITION;
        end
      end
      asmc_pkg::MODE_DISARMED: begin
        if (req_type == asmc_pkg::REQ_SHUTDOWN) begin
          mode_nxt = asmc_pkg::MODE_SHUTDOWN;
          status   = asmc_pkg::ST_TRANSITION;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    code = asmc_pkg::mode_code(mode_nxt);
    result.mode         = code;
    result.event_status = status;
    result.screen_on    = (code == asmc_pkg::MODE_CODE_UNINIT) ||
                          (code == asmc_pkg::MODE_CODE_INIT) ||
                          (code == asmc_pkg::MODE_CODE_DISARMED);
    if (code == asmc_pkg::MODE_CODE_ARMED) begin
      result.motor_sound = asmc_pkg::MOTOR_LOUD;
    end else if ((code == asmc_pkg::MODE_CODE_INIT) ||
                 (code == asmc_pkg::MODE_CODE_DISARMED)) begin
      result.motor_sound = asmc_pkg::MOTOR_QUIET;
    end else begin
      result.motor_sound = asmc_pkg::MOTOR_SILENT;
    end
  end

endmodule

// File: hdl/arm_sequence_mode_controller_unit.sv
// Arm sequence mode controller. Each accepted event item yields exactly one result item
// carrying the mode after the event, the screen and motor outputs of that mode, and an
// event status. One item is taken every clock cycle: the mode and done-flag registers
// update at acceptance through a single level of decode logic, and the result is registered
// into an output register alongside them. The input is only held off while that output
// register is full and not being taken. The active subsystem mask may be rewritten
// while the block is idle; an all-zero mask moves the block to initialized on the
// next event.
module arm_sequence_mode_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,    // active_subsystem_mask
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [2:0] req_type, [6:3] subsystem_index, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata     // [2:0] mode, [3] screen_on, [5:4] motor_sound,
                                    // [8:6] event_status, [15:9] zero
);

  logic [7:0]        mask_r;
  asmc_pkg::mode_t   mode_r;
  asmc_pkg::mode_t   mode_nxt;
  logic [7:0]        done_flags_r;
  logic [7:0]        done_flags_nxt;
  asmc_pkg::result_t result;
  asmc_pkg::result_t out_r;
  logic              out_valid_r;
  logic              in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  asmc_step u_step (
    .mode            (mode_r),
    .done_flags      (done_flags_r),
    .mask            (mask_r),
    .req_type        (in_tdata[2:0]),
    .subsystem_index (in_tdata[6:3]),
    .mode_nxt        (mode_nxt),
    .done_flags_nxt  (done_flags_nxt),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= asmc_pkg::MASK_RESET;
      mode_r       <= asmc_pkg::MODE_UNINIT;
      done_flags_r <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (in_accept) begin
        mode_r       <= mode_nxt;
        done_flags_r <= done_flags_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

`ifndef NO_ASSERTIONS
  // Done flags are only ever set, never cleared, outside of reset.
  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((done_flags_r & $past(done_flags_r)) == $past(done_flags_r)))
    else $error("done flag cleared");

  // Once the block has left uninitialized mode, the done flags stay put.
  a_flags_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != asmc_pkg::MODE_UNINIT) |=> $stable(done_flags_r))
    else $error("done flags changed outside uninitialized mode");

  // A newly initialized subsystem can only be reported in uninitialized or initialized mode.
  a_new_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.event_status == asmc_pkg::ST_NEW)) |->
      ((out_r.mode == asmc_pkg::MODE_CODE_UNINIT) || (out_r.mode == asmc_pkg::MODE_CODE_INIT)))
    else $error("newly initialized status in wrong mode");
`endif

endmodule
